[hw/rtl/sgb_pkg.sv]
package sgb_pkg;

    localparam int MAX_WIDTH        = 2048;
    localparam int MAX_HEIGHT       = 2048;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 11;
    localparam int DIM_W      = 12;
    localparam int OW_W       = 16;
    localparam int CW_W       = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int HS_W   = PIX_W + WEIGHT_FRAC_BITS;
    localparam int HP_W   = CW_W + PIX_W;
    localparam int HSUM_W = HP_W + 2;
    localparam int VP_W   = CW_W + HS_W;
    localparam int VSUM_W = VP_W + 2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
    localparam logic [OW_W-1:0]  OUTER_RST  = OW_W'(17961);
    localparam logic [CW_W-1:0]  CENTER_RST = CW_W'(29614);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_OUTER  = 2'd2,
        REG_CENTER = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   center;
        logic [PIX_W-1:0]   right;
        logic               emit_prev;
        logic               emit_cur;
        logic               row_zero;
        logic               last_job;
        logic               frame_end;
        logic               defer_cur;
        logic               flush_held;
    } job_t;

    typedef struct packed {
        logic [PIX_W-1:0]   smoothed;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last_of_run;
        logic               frame_done;
    } result_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HSUM,
        B_VMUL,
        B_VSUM,
        B_HELD
    } back_state_t;

endpackage

[hw/rtl/sgb_front.sv]
module sgb_front
    import sgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [PIX_W-1:0]   pixel,
    input  logic [DIM_W-1:0]   frame_width,
    input  logic [DIM_W-1:0]   frame_height,
    output logic               job_push,
    output job_t               job,
    input  logic               job_full
);

    logic [PIX_W-1:0]   prev_reg, prev_next;
    logic [PIX_W-1:0]   prev_prev_reg, prev_prev_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               pend_valid_reg, pend_valid_next;
    job_t               pend_reg, pend_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic             accept, row_end, last_row, has_a, both;
    job_t             job_a, job_b;

    always_comb
    begin
        if (frame_width == '0)
            w_eff = DIM_W'(1);
        else if (frame_width > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width;
        if (frame_height == '0)
            h_eff = DIM_W'(1);
        else if (frame_height > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = frame_height;
    end

    assign full     = pend_valid_reg | job_full;
    assign accept   = push & ~full;
    assign row_end  = {1'b0, col_reg} >= (w_eff - DIM_W'(1));
    assign last_row = {1'b0, row_reg} >= (h_eff - DIM_W'(1));
    assign has_a    = col_reg != '0;
    assign both     = has_a & row_end;

    always_comb
    begin
        job_a            = '0;
        job_a.x          = col_reg - COORD_W'(1);
        job_a.row        = row_reg;
        job_a.left       = (col_reg == COORD_W'(1)) ? prev_reg : prev_prev_reg;
        job_a.center     = prev_reg;
        job_a.right      = pixel;
        job_a.emit_prev  = row_reg != '0;
        job_a.emit_cur   = last_row;
        job_a.row_zero   = row_reg == '0;
        job_a.last_job   = ~row_end;
        job_a.frame_end  = row_end & last_row;
        job_a.defer_cur  = both & (row_reg != '0) & last_row;
        job_a.flush_held = 1'b0;

        job_b            = '0;
        job_b.x          = col_reg;
        job_b.row        = row_reg;
        job_b.left       = has_a ? prev_reg : pixel;
        job_b.center     = pixel;
        job_b.right      = pixel;
        job_b.emit_prev  = row_reg != '0;
        job_b.emit_cur   = last_row;
        job_b.row_zero   = row_reg == '0;
        job_b.last_job   = 1'b1;
        job_b.frame_end  = row_end & last_row;
        job_b.defer_cur  = 1'b0;
        job_b.flush_held = both & (row_reg != '0) & last_row;
    end

    always_comb
    begin
        if (pend_valid_reg)
        begin
            job_push = ~job_full;
            job      = pend_reg;
        end
        else
        begin
            job_push = accept & (has_a | row_end);
            job      = has_a ? job_a : job_b;
        end
    end

    always_comb
    begin
        prev_next       = prev_reg;
        prev_prev_next  = prev_prev_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (pend_valid_reg && !job_full)
            pend_valid_next = 1'b0;
        if (accept)
        begin
            prev_prev_next = prev_reg;
            prev_next      = pixel;
            if (both)
            begin
                pend_valid_next = 1'b1;
                pend_next       = job_b;
            end
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_W'(1);
            end
            else
                col_next = col_reg + COORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            prev_prev_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg       <= prev_next;
            prev_prev_reg  <= prev_prev_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

[hw/rtl/sgb_job_fifo.sv]
module sgb_job_fifo
    import sgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic valid
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t               store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = count_reg == (PTR_W + 1)'(DEPTH);
    assign valid   = count_reg != '0;
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(do_wr) - (PTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[hw/rtl/sgb_back.sv]
module sgb_back
    import sgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    input  logic [OW_W-1:0]    outer_weight,
    input  logic [CW_W-1:0]    center_weight,
    output logic               empty,
    input  logic               pop,
    output result_t            result
);

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam logic [VSUM_W-1:0] ROUND_HALF = VSUM_W'(1) << (2 * WEIGHT_FRAC_BITS - 1);

    back_state_t        state_reg, state_next;
    job_t               job_reg;
    logic [HP_W-1:0]    hp0_reg, hp1_reg, hp2_reg;
    logic [HS_W-1:0]    hs_reg;
    logic [HS_W-1:0]    older_rd_reg, newer_rd_reg;
    logic [VP_W-1:0]    vp0_reg, vp1_reg, vp2_reg;
    logic               phase_cur_reg, phase_cur_next;
    result_t            held_reg;

    logic [HS_W-1:0]    older_mem [MAX_WIDTH];
    logic [HS_W-1:0]    newer_mem [MAX_WIDTH];

    result_t            oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_PTR_W:0]  oq_count_reg;
    logic               out_full, out_pop;

    logic               mem_rd, mem_we, vmul_load, out_push, held_load;
    result_t            out_item, cur_item;
    logic [HSUM_W-1:0]  hsum_full;
    logic [HS_W-1:0]    hs_sat;
    logic [HS_W-1:0]    op_a, op_b, op_c;
    logic [VSUM_W-1:0]  vsum_full;
    logic [VSUM_W-2*WEIGHT_FRAC_BITS-1:0] rounded;
    logic [PIX_W-1:0]   smooth_val;
    logic               is_last;

    // horizontal sum, saturated to the line store width
    assign hsum_full = HSUM_W'(hp0_reg) + HSUM_W'(hp1_reg) + HSUM_W'(hp2_reg);
    assign hs_sat    = (hsum_full[HSUM_W-1:HS_W] != '0) ? '1 : hsum_full[HS_W-1:0];

    always_comb
    begin
        if (phase_cur_reg)
        begin
            op_a = job_reg.row_zero ? hs_reg : newer_rd_reg;
            op_b = hs_reg;
            op_c = hs_reg;
        end
        else
        begin
            op_a = older_rd_reg;
            op_b = newer_rd_reg;
            op_c = hs_reg;
        end
    end

    assign vsum_full  = VSUM_W'(vp0_reg) + VSUM_W'(vp1_reg) + VSUM_W'(vp2_reg) + ROUND_HALF;
    assign rounded    = vsum_full[VSUM_W-1:2*WEIGHT_FRAC_BITS];
    assign smooth_val = (rounded[$bits(rounded)-1:PIX_W] != '0) ? '1 : rounded[PIX_W-1:0];
    assign is_last    = job_reg.last_job & (phase_cur_reg | ~job_reg.emit_cur);

    always_comb
    begin
        cur_item.smoothed    = smooth_val;
        cur_item.row         = phase_cur_reg ? job_reg.row : job_reg.row - COORD_W'(1);
        cur_item.col         = job_reg.x;
        cur_item.last_of_run = is_last;
        cur_item.frame_done  = is_last & job_reg.frame_end;
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop   = 1'b0;
        mem_rd    = 1'b0;
        mem_we    = 1'b0;
        vmul_load = 1'b0;
        out_push  = 1'b0;
        held_load = 1'b0;
        out_item  = cur_item;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    mem_rd  = 1'b1;
                end
            end
            B_HSUM:
                mem_we = 1'b1;
            B_VMUL:
                vmul_load = 1'b1;
            B_VSUM:
            begin
                if (phase_cur_reg && job_reg.defer_cur)
                    held_load = 1'b1;
                else if (!out_full)
                    out_push = 1'b1;
            end
            B_HELD:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    out_item = held_reg;
                end
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        phase_cur_next = phase_cur_reg;
        unique case (state_reg)
            B_IDLE:
                if (job_valid)
                    state_next = B_HSUM;
            B_HSUM:
            begin
                phase_cur_next = ~job_reg.emit_prev;
                state_next = (job_reg.emit_prev | job_reg.emit_cur) ? B_VMUL : B_IDLE;
            end
            B_VMUL:
                state_next = B_VSUM;
            B_VSUM:
            begin
                if (held_load)
                    state_next = B_IDLE;
                else if (out_push)
                begin
                    if (phase_cur_reg)
                        state_next = B_IDLE;
                    else
                    begin
                        phase_cur_next = 1'b1;
                        if (job_reg.flush_held)
                            state_next = B_HELD;
                        else if (job_reg.emit_cur)
                            state_next = B_VMUL;
                        else
                            state_next = B_IDLE;
                    end
                end
            end
            B_HELD:
                if (out_push)
                    state_next = B_VMUL;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            phase_cur_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_cur_reg <= phase_cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
            hp0_reg <= HP_W'(outer_weight) * HP_W'(job.left);
            hp1_reg <= HP_W'(center_weight) * HP_W'(job.center);
            hp2_reg <= HP_W'(outer_weight) * HP_W'(job.right);
        end
        if (mem_we)
            hs_reg <= hs_sat;
        if (vmul_load)
        begin
            vp0_reg <= VP_W'(outer_weight) * VP_W'(op_a);
            vp1_reg <= VP_W'(center_weight) * VP_W'(op_b);
            vp2_reg <= VP_W'(outer_weight) * VP_W'(op_c);
        end
        if (held_load)
            held_reg <= cur_item;
    end

    // line stores: rows r-2 and r-1
    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            older_rd_reg <= older_mem[job.x[ADDR_W-1:0]];
            newer_rd_reg <= newer_mem[job.x[ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            older_mem[job_reg.x[ADDR_W-1:0]] <= job_reg.row_zero ? hs_sat : newer_rd_reg;
            newer_mem[job_reg.x[ADDR_W-1:0]] <= hs_sat;
        end
    end

    // result queue
    assign out_full = oq_count_reg == (OQ_PTR_W + 1)'(OQ_DEPTH);
    assign empty    = oq_count_reg == '0;
    assign out_pop  = pop & ~empty;
    assign result   = oq_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (out_push)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_W'(1);
            if (out_pop)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_W'(1);
            oq_count_reg <= oq_count_reg + (OQ_PTR_W + 1)'(out_push)
                            - (OQ_PTR_W + 1)'(out_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
            oq_reg[oq_wr_reg] <= out_item;
    end

endmodule

[hw/rtl/separable_gaussian_blur_3x3.sv]
// Separable 3x3 Gaussian blur, replicate borders, 8-bit grey pixels.
// Input queue: drive pixel and push; a pixel is taken on a clock edge with
// push high and full low. Pixels arrive in raster order, frame after frame.
// Result queue: while empty is low the oldest result sits on smoothed,
// out_row, out_col, last_of_run and frame_done; pop takes it. A pixel
// yields zero to four results; last_of_run marks the last one it caused,
// frame_done the last one of the frame.
// Config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
// always high): 0 width, 1 height, 2 outer weight (Q0.16), 3 center
// weight (Q1.16). Write only while no pixel is in flight.
// Path: a result that a pixel completes passes through the job queue, the
// popped job's horizontal products, the horizontal sum, the vertical
// products and the result queue.
// Sequencing: the back end handles one column job at a time through its
// shared multiply/sum sequence (pop, horizontal sum, then a vertical
// multiply and sum per result, with a step to release a held result).
// A stalled result queue (2 deep) stalls the back end; the job queue then
// fills and full rises.
// Reset clears counters, pixel history and queues; line stores need no
// clearing since row 0 writes both before they are read.
module separable_gaussian_blur_3x3
    import sgb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      smoothed,
    output logic [COORD_W-1:0]    out_row,
    output logic [COORD_W-1:0]    out_col,
    output logic                  last_of_run,
    output logic                  frame_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIM_W-1:0] width_reg, height_reg;
    logic [OW_W-1:0]  outer_reg;
    logic [CW_W-1:0]  center_reg;
    logic             cfg_we;

    logic    job_push, job_full, job_valid, job_pop;
    job_t    job_in, job_out;
    result_t result;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            outer_reg  <= OUTER_RST;
            center_reg <= CENTER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_OUTER:  outer_reg  <= cfg_data[OW_W-1:0];
                REG_CENTER: center_reg <= cfg_data[CW_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    sgb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .job_push     (job_push),
        .job          (job_in),
        .job_full     (job_full)
    );

    sgb_job_fifo u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .valid   (job_valid)
    );

    sgb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_valid),
        .job           (job_out),
        .job_pop       (job_pop),
        .outer_weight  (outer_reg),
        .center_weight (center_reg),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

    assign smoothed    = result.smoothed;
    assign out_row     = result.row;
    assign out_col     = result.col;
    assign last_of_run = result.last_of_run;
    assign frame_done  = result.frame_done;

endmodule
